// ----- sv/tpkl_pkg.sv -----
// ----------------------------------------------------------------------------
// tpkl_pkg
// shared types and constants of the throttle pid block with knob speed cap
// ----------------------------------------------------------------------------
package tpkl_pkg;

   localparam int KNOB_AVG_DEPTH_DEF = 8;
   localparam int KNOB_W             = 10;
   localparam int SPEED_W            = 16;
   localparam int GAIN_W             = 16;
   localparam int TIME_W             = 32;
   localparam int CSR_IDX_W          = 3;
   localparam int CSR_DATA_W         = 16;
   localparam int ERR_W              = 18;
   localparam int INTEG_W            = 20;
   localparam int MUL_A_W            = 20;
   localparam int MUL_B_W            = 16;
   localparam int MUL_P_W            = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W            = 36;
   localparam int DIV_D_W            = 32;
   localparam int TERM_W             = 38;

   localparam logic [INTEG_W-1:0] INTEG_MAX      = 20'd786432;
   localparam int                 INTEG_STEP_DIV = 300;
   localparam int                 CAP_DIV        = 10;

   localparam logic [15:0] PROP_GAIN_RST = 16'd256;
   localparam logic [15:0] DERIV_GAIN_RST = 16'd0;
   localparam logic [15:0] INTEG_GAIN_RST = 16'd0;
   localparam logic [15:0] OUT_MIN_RST   = 16'd0;
   localparam logic [15:0] OUT_MAX_RST   = 16'd256;
   localparam logic [15:0] INTERVAL_RST  = 16'd50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_DERIV_GAIN = 3'd1,
      CSR_INTEG_GAIN = 3'd2,
      CSR_OUT_MIN    = 3'd3,
      CSR_OUT_MAX    = 3'd4,
      CSR_INTERVAL   = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CAP,
      ST_PMUL,
      ST_IDIV,
      ST_DMUL,
      ST_DDIV,
      ST_IMUL,
      ST_SUM,
      ST_DONE
   } state_type;

endpackage

// ----- sv/throttle_pid_with_knob_limit_unit.sv -----
// ----------------------------------------------------------------------------
// throttle_pid_with_knob_limit_unit
// pid throttle loop with integral clamp and knob-derived speed cap
// ----------------------------------------------------------------------------
// One transaction in gives one throttle value out. The knob sample is averaged
// over a ring and the mean, times 256 and divided by ten, caps the target
// speed; a target of zero or less gives zero and clears the integral. A pid
// update runs once more than the interval register, in ms, has passed, otherwise
// the held output is repeated. When the proportional product reaches 65536 the
// integral is cleared and its step skipped. Every product goes through one
// bit-serial multiplier and every quotient through one restoring divider, used
// in turn for the cap, the integral step and the derivative. A finished result
// waits in the done state until the output is free. The next transaction is
// taken while a result still waits on the output.
module throttle_pid_with_knob_limit_unit #(
   parameter int KNOB_AVG_DEPTH = tpkl_pkg::KNOB_AVG_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [tpkl_pkg::SPEED_W-1:0] req_measured_speed,
   input  logic signed [tpkl_pkg::SPEED_W-1:0] req_target_speed,
   input  logic [tpkl_pkg::KNOB_W-1:0]         req_knob_sample,
   input  logic [tpkl_pkg::TIME_W-1:0]         req_now_ms,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [tpkl_pkg::SPEED_W-1:0] rsp_throttle,
   input  logic                              csr_we,
   input  logic [tpkl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tpkl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tpkl_pkg::*;

   localparam int PTR_W = (KNOB_AVG_DEPTH > 1) ? $clog2(KNOB_AVG_DEPTH) : 1;
   localparam int FILL_W = $clog2(KNOB_AVG_DEPTH + 1);
   localparam int SUM_W = KNOB_W + FILL_W;
   localparam int CDV_W = FILL_W + 4;
   localparam int CAP_W = ERR_W - 1;
   localparam int ACC_W = INTEG_W + 2;
   localparam int OUT_W = TERM_W - 8;

   // configuration
   logic [GAIN_W-1:0]         kp_ff, kd_ff, ki_ff;
   logic signed [SPEED_W-1:0] omin_ff, omax_ff;
   logic [15:0]               ival_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= PROP_GAIN_RST;
         kd_ff   <= DERIV_GAIN_RST;
         ki_ff   <= INTEG_GAIN_RST;
         omin_ff <= OUT_MIN_RST;
         omax_ff <= OUT_MAX_RST;
         ival_ff <= INTERVAL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PROP_GAIN:  kp_ff   <= csr_wdata;
            CSR_DERIV_GAIN: kd_ff   <= csr_wdata;
            CSR_INTEG_GAIN: ki_ff   <= csr_wdata;
            CSR_OUT_MIN:    omin_ff <= csr_wdata;
            CSR_OUT_MAX:    omax_ff <= csr_wdata;
            CSR_INTERVAL:   ival_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // state
   state_type                 state_ff, state_in;
   logic [KNOB_W-1:0]         ring_ff [KNOB_AVG_DEPTH];
   logic [PTR_W-1:0]          ptr_ff, ptr_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [INTEG_W-1:0]        integ_ff, integ_in;
   logic signed [ERR_W-1:0]   lerr_ff, lerr_in;
   logic signed [SPEED_W-1:0] held_ff, held_in;
   logic [TIME_W-1:0]         lupd_ff, lupd_in;
   logic signed [SPEED_W-1:0] meas_ff, meas_in, targ_ff, targ_in;
   logic [TIME_W-1:0]         now_ff, now_in, elap_ff, elap_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [TERM_W-1:0]  pterm_ff, pterm_in, dterm_ff, dterm_in;
   logic signed [TERM_W-1:0]  iterm_ff, iterm_in;
   logic signed [SPEED_W-1:0] res_ff, res_in;
   logic                      rspv_ff, rspv_in;
   logic signed [SPEED_W-1:0] rspd_ff, rspd_in;

   // shared arithmetic
   logic                 mul_start, mul_done, div_start, div_done;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_P_W-1:0]   mul_p;
   logic [DIV_N_W-1:0]   div_n, div_q;
   logic [DIV_D_W-1:0]   div_d;

   tpkl_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .product(mul_p)
   );

   tpkl_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_n),
      .divisor(div_d), .done(div_done), .quotient(div_q)
   );

   logic                      accept, full;
   logic [KNOB_W-1:0]         old_knob;
   logic [CAP_W-1:0]          cap;
   logic signed [ERR_W-1:0]   teff;
   logic [TIME_W-1:0]         elap;
   logic [ERR_W-2:0]          err_mag;
   logic signed [ERR_W:0]     de;
   logic [ERR_W-1:0]          de_mag;
   logic signed [TERM_W-1:0]  pmag_s, dmag_s;
   logic signed [ACC_W-1:0]   acc;
   logic signed [TERM_W-1:0]  total;
   logic signed [OUT_W-1:0]   scaled;

   assign accept   = req_valid && req_ready;
   assign full     = (fill_ff == FILL_W'(KNOB_AVG_DEPTH));
   assign old_knob = ring_ff[ptr_ff];
   assign err_mag  = err_ff[ERR_W-1] ? (ERR_W-1)'(-err_ff) : err_ff[ERR_W-2:0];
   assign de       = {err_ff[ERR_W-1], err_ff} - {lerr_ff[ERR_W-1], lerr_ff};
   assign de_mag   = de[ERR_W] ? ERR_W'(-de) : de[ERR_W-1:0];

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      integ_in  = integ_ff;
      lerr_in   = lerr_ff;
      held_in   = held_ff;
      lupd_in   = lupd_ff;
      meas_in   = meas_ff;
      targ_in   = targ_ff;
      now_in    = now_ff;
      elap_in   = elap_ff;
      err_in    = err_ff;
      pterm_in  = pterm_ff;
      dterm_in  = dterm_ff;
      iterm_in  = iterm_ff;
      res_in    = res_ff;
      rspv_in   = rspv_ff && !rsp_ready;
      rspd_in   = rspd_ff;
      mul_start = 1'b0;
      mul_a     = MUL_A_W'(err_mag);
      mul_b     = kp_ff;
      div_start = 1'b0;
      div_n     = DIV_N_W'({err_mag, 8'b0});
      div_d     = DIV_D_W'(INTEG_STEP_DIV);
      cap       = div_q[CAP_W-1:0];
      teff      = (ERR_W'(targ_ff) > $signed({1'b0, cap})) ? $signed({1'b0, cap})
                                                          : ERR_W'(targ_ff);
      elap      = now_ff - lupd_ff;
      pmag_s    = $signed(TERM_W'(mul_p));
      dmag_s    = $signed(TERM_W'(div_q));
      acc       = $signed(ACC_W'(integ_ff));
      total     = pterm_ff + dterm_ff + iterm_ff;
      scaled    = OUT_W'(total >>> 8);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               meas_in = req_measured_speed;
               targ_in = req_target_speed;
               now_in  = req_now_ms;
               if (full) begin
                  sum_in = sum_ff - SUM_W'(old_knob) + SUM_W'(req_knob_sample);
               end else begin
                  sum_in  = sum_ff + SUM_W'(req_knob_sample);
                  fill_in = fill_ff + 1'b1;
               end
               ptr_in = (ptr_ff == PTR_W'(KNOB_AVG_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
               if (req_target_speed <= 0) begin
                  integ_in = '0;
                  held_in  = '0;
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  div_start = 1'b1;
                  div_n     = DIV_N_W'({sum_in, 8'b0});
                  div_d     = DIV_D_W'(CDV_W'(fill_in) * CDV_W'(CAP_DIV));
                  state_in  = ST_CAP;
               end
            end
         end
         ST_CAP: begin
            if (div_done) begin
               err_in  = teff - ERR_W'(meas_ff);
               elap_in = elap;
               if (elap > TIME_W'(ival_ff)) begin
                  mul_start = 1'b1;
                  mul_a     = MUL_A_W'(err_in[ERR_W-1] ? (ERR_W-1)'(-err_in)
                                                      : err_in[ERR_W-2:0]);
                  mul_b     = kp_ff;
                  state_in  = ST_PMUL;
               end else begin
                  res_in   = held_ff;
                  state_in = ST_DONE;
               end
            end
         end
         ST_PMUL: begin
            if (mul_done) begin
               pterm_in = err_ff[ERR_W-1] ? -pmag_s : pmag_s;
               if (mul_p < MUL_P_W'(65536)) begin
                  div_start = 1'b1;
                  state_in  = ST_IDIV;
               end else begin
                  integ_in  = '0;
                  mul_start = 1'b1;
                  mul_a     = MUL_A_W'(de_mag);
                  mul_b     = kd_ff;
                  state_in  = ST_DMUL;
               end
            end
         end
         ST_IDIV: begin
            if (div_done) begin
               if (err_ff[ERR_W-1]) begin
                  acc = acc - $signed(ACC_W'(div_q));
               end else begin
                  acc = acc + $signed(ACC_W'(div_q));
               end
               if (acc < 0) begin
                  integ_in = '0;
               end else if (acc > $signed(ACC_W'(INTEG_MAX))) begin
                  integ_in = INTEG_MAX;
               end else begin
                  integ_in = acc[INTEG_W-1:0];
               end
               mul_start = 1'b1;
               mul_a     = MUL_A_W'(de_mag);
               mul_b     = kd_ff;
               state_in  = ST_DMUL;
            end
         end
         ST_DMUL: begin
            if (mul_done) begin
               div_start = 1'b1;
               div_n     = DIV_N_W'(mul_p);
               div_d     = elap_ff;
               state_in  = ST_DDIV;
            end
         end
         ST_DDIV: begin
            if (div_done) begin
               dterm_in  = de[ERR_W] ? -dmag_s : dmag_s;
               mul_start = 1'b1;
               mul_a     = MUL_A_W'(integ_ff);
               mul_b     = ki_ff;
               state_in  = ST_IMUL;
            end
         end
         ST_IMUL: begin
            if (mul_done) begin
               iterm_in = $signed(TERM_W'(mul_p >> 8));
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (scaled > OUT_W'(omax_ff)) begin
               res_in = omax_ff;
            end else begin
               res_in = scaled[SPEED_W-1:0];
            end
            if (scaled < OUT_W'(omin_ff) || omin_ff > omax_ff) begin
               if (scaled < OUT_W'(omin_ff) || scaled > OUT_W'(omax_ff)) begin
                  res_in = omin_ff;
               end
            end
            lerr_in  = err_ff;
            lupd_in  = now_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rspv_ff || rsp_ready) begin
               rspv_in  = 1'b1;
               rspd_in  = res_ff;
               held_in  = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      meas_ff  <= meas_in;
      targ_ff  <= targ_in;
      now_ff   <= now_in;
      elap_ff  <= elap_in;
      err_ff   <= err_in;
      pterm_ff <= pterm_in;
      dterm_ff <= dterm_in;
      iterm_ff <= iterm_in;
      res_ff   <= res_in;
      rspd_ff  <= rspd_in;
      if (accept) begin
         ring_ff[ptr_ff] <= req_knob_sample;
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff   <= '0;
         fill_ff  <= '0;
         sum_ff   <= '0;
         integ_ff <= '0;
         lerr_ff  <= '0;
         held_ff  <= '0;
         lupd_ff  <= '0;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         fill_ff  <= fill_in;
         sum_ff   <= sum_in;
         integ_ff <= integ_in;
         lerr_ff  <= lerr_in;
         held_ff  <= held_in;
         lupd_ff  <= lupd_in;
         rspv_ff  <= rspv_in;
      end
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rspv_ff;
   assign rsp_throttle = rspd_ff;

   a_integ_range: assert property (@(posedge clock) disable iff (reset)
      integ_ff <= INTEG_MAX) else $error("integral out of range");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(KNOB_AVG_DEPTH)) else $error("fill count overrun");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready) else $error("transaction taken while busy");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rspv_ff && !rsp_ready) |=> $stable(rspd_ff)) else $error("result lost");

endmodule

// ----- sv/tpkl_mul.sv -----
// ----------------------------------------------------------------------------
// tpkl_mul
// unsigned shift-and-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module tpkl_mul #(
   parameter int A_W = tpkl_pkg::MUL_A_W,
   parameter int B_W = tpkl_pkg::MUL_B_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [A_W-1:0] a,
   input  logic [B_W-1:0] b,
   output logic           done,
   output logic [A_W+B_W-1:0] product
);
   import tpkl_pkg::*;

   localparam int P_W = A_W + B_W;
   localparam int C_W = $clog2(B_W + 1);

   logic [P_W-1:0] acc_ff, acc_in, a_ff, a_in;
   logic [B_W-1:0] b_ff, b_in;
   logic [C_W-1:0] cnt_ff, cnt_in;
   logic           run_ff, run_in, done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         a_in   = P_W'(a);
         b_in   = b;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = acc_ff + (b_ff[0] ? a_ff : '0);
         a_in   = a_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == C_W'(B_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- sv/tpkl_div.sv -----
// ----------------------------------------------------------------------------
// tpkl_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tpkl_div #(
   parameter int N_W = tpkl_pkg::DIV_N_W,
   parameter int D_W = tpkl_pkg::DIV_D_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           done,
   output logic [N_W-1:0] quotient
);
   import tpkl_pkg::*;

   localparam int C_W = $clog2(N_W + 1);

   logic [N_W-1:0] quo_ff, quo_in;
   logic [D_W-1:0] rem_ff, rem_in, dvr_ff, dvr_in;
   logic [C_W-1:0] cnt_ff, cnt_in;
   logic           run_ff, run_in, done_ff, done_in;
   logic [D_W:0]   trial, diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvr_in  = dvr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[N_W-1]};
      diff    = trial - {1'b0, dvr_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvr_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[D_W]) begin
            rem_in = diff[D_W-1:0];
            quo_in = {quo_ff[N_W-2:0], 1'b1};
         end else begin
            rem_in = trial[D_W-1:0];
            quo_in = {quo_ff[N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == C_W'(N_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvr_ff <= dvr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- tb/sv/throttle_pid_with_knob_limit_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// throttle_pid_with_knob_limit_unit_test
// self-checking bench for the pid throttle loop with knob speed cap
// ----------------------------------------------------------------------------
// A short table of directed transactions, some with the throttle typed in,
// is followed by random ticks under several gain and limit settings. Each
// accepted tick is run through a fixed-point copy of the controller and the
// expected throttle is queued; every result is compared with the oldest entry.
// Both handshakes idle at random, with short gaps, a few long ones and a quiet
// phase.
// ----------------------------------------------------------------------------
module throttle_pid_with_knob_limit_unit_test;
   import tpkl_pkg::*;

   localparam int  RING_DEPTH  = KNOB_AVG_DEPTH_DEF;
   localparam int  PHASE_ITEMS = 150;
   localparam int  NUM_PHASES  = 7;
   localparam int  DRAIN_WAIT  = 200;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct {
      logic signed [SPEED_W-1:0] meas;
      logic signed [SPEED_W-1:0] tgt;
      logic [KNOB_W-1:0]         knob;
      logic [TIME_W-1:0]         now;
      bit                        known;
      logic signed [SPEED_W-1:0] thr;
   } tick_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [SPEED_W-1:0] req_measured_speed;
   logic signed [SPEED_W-1:0] req_target_speed;
   logic [KNOB_W-1:0]         req_knob_sample;
   logic [TIME_W-1:0]         req_now_ms;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [SPEED_W-1:0] rsp_throttle;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // controller copy
   longint kp, kd, ki, lim_lo, lim_hi, interval;
   longint knob_ring_m [RING_DEPTH];
   int     ring_ptr, ring_fill;
   longint ring_sum, integ_m, last_err_m, held_m;
   logic [TIME_W-1:0] last_ms_m;

   logic signed [SPEED_W-1:0] throttle_queue [$];
   int     error_count;
   longint cycle_count = 0;
   bit     quiet;
   logic [TIME_W-1:0] clock_ms;

   tick_row_type dir_rows [12] = '{
      '{16'sd0,      16'sd0,      10'd0,    32'd0,           1'b1, 16'sd0},
      '{16'sh7FFF,   16'sh8000,   10'd1023, 32'd10,          1'b1, 16'sd0},
      '{16'sh8000,   16'sh7FFF,   10'd1023, 32'd100,         1'b1, 16'sd256},
      '{16'sd0,      16'sd256,    10'd512,  32'd120,         1'b1, 16'sd256},
      '{16'sh7FFF,   16'sd1,      10'd700,  32'd200,         1'b1, 16'sd0},
      '{16'sd256,    16'sd300,    10'd800,  32'd300,         1'b0, 16'sd0},
      '{16'sd300,    16'sd300,    10'd600,  32'd400,         1'b0, 16'sd0},
      '{16'sd100,    16'sd150,    10'd300,  32'hFFFF_FFF0,   1'b0, 16'sd0},
      '{16'sd120,    16'sd150,    10'd200,  32'h0000_0040,   1'b0, 16'sd0},
      '{16'sd0,      16'sh7FFF,   10'd1023, 32'h0000_0100,   1'b0, 16'sd0},
      '{16'sd20000,  16'sd20000,  10'd0,    32'h0000_0200,   1'b0, 16'sd0},
      '{16'sd50,     -16'sd1,     10'd5,    32'h0000_0300,   1'b0, 16'sd0}
   };

   throttle_pid_with_knob_limit_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_measured_speed(req_measured_speed), .req_target_speed(req_target_speed),
      .req_knob_sample(req_knob_sample), .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_throttle(rsp_throttle),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [SPEED_W-1:0] predict_throttle(
      logic signed [SPEED_W-1:0] meas, logic signed [SPEED_W-1:0] tgt,
      logic [KNOB_W-1:0] knob, logic [TIME_W-1:0] now);
      longint m, t, cap, err, pterm, dterm, iterm, total, el;
      logic [TIME_W-1:0] since;
      int p;
      p = ring_ptr;
      if (ring_fill >= RING_DEPTH) ring_sum -= knob_ring_m[p];
      else ring_fill++;
      knob_ring_m[p] = knob;
      ring_sum += knob;
      ring_ptr = (p + 1) % RING_DEPTH;
      cap = (ring_sum * 256) / (ring_fill * 10);
      m = meas;
      t = tgt;
      if (t <= 0) begin
         integ_m = 0;
         held_m = 0;
         return '0;
      end
      if (t > cap) t = cap;
      since = now - last_ms_m;
      el = since;
      if (el > interval) begin
         err = t - m;
         pterm = err * kp;
         if (pterm < 65536 && pterm > -65536) integ_m = integ_m + (err * 256) / 300;
         else integ_m = 0;
         if (integ_m < 0) integ_m = 0;
         if (integ_m > longint'(INTEG_MAX)) integ_m = INTEG_MAX;
         dterm = ((err - last_err_m) * kd) / el;
         iterm = (integ_m * ki) / 256;
         total = pterm + dterm + iterm;
         if (total >= 0) total = total / 256;
         else total = -((-total + 255) / 256);
         if (total > lim_hi) total = lim_hi;
         if (total < lim_lo) total = lim_lo;
         held_m = total;
         last_err_m = err;
         last_ms_m = now;
      end
      return held_m[SPEED_W-1:0];
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   task automatic send_tick(tick_row_type row);
      int gap;
      logic signed [SPEED_W-1:0] pred;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_measured_speed <= row.meas;
      req_target_speed   <= row.tgt;
      req_knob_sample    <= row.knob;
      req_now_ms         <= row.now;
      do @(posedge clock); while (!req_ready);
      pred = predict_throttle(row.meas, row.tgt, row.knob, row.now);
      throttle_queue.push_back(row.known ? row.thr : pred);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PROP_GAIN:  kp = value;
         CSR_DERIV_GAIN: kd = value;
         CSR_INTEG_GAIN: ki = value;
         CSR_OUT_MIN:    lim_lo = $signed(value);
         CSR_OUT_MAX:    lim_hi = $signed(value);
         CSR_INTERVAL:   interval = value;
         default: ;
      endcase
   endtask

   task automatic set_phase(int ph);
      logic [CSR_DATA_W-1:0] v [6];
      req_valid <= 1'b0;
      while (throttle_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      case (ph)
         1: v = '{16'd256, 16'd64, 16'd512, -16'sd2560, 16'sd2560, 16'd10};
         2: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd0};
         3: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF};
         4: v = '{16'd16, 16'd1000, 16'd30000, 16'sd1000, -16'sd1000, 16'd5};
         5: v = '{16'd300, 16'd200, 16'd4000, 16'h8000, 16'h7FFF, 16'd20};
         default: begin
            foreach (v[i]) v[i] = CSR_DATA_W'($urandom);
            v[5] = CSR_DATA_W'($urandom_range(0, 100));
         end
      endcase
      write_csr(CSR_PROP_GAIN, v[0]);
      write_csr(CSR_DERIV_GAIN, v[1]);
      write_csr(CSR_INTEG_GAIN, v[2]);
      write_csr(CSR_OUT_MIN, v[3]);
      write_csr(CSR_OUT_MAX, v[4]);
      write_csr(CSR_INTERVAL, v[5]);
   endtask

   function automatic tick_row_type random_tick();
      tick_row_type row;
      int r;
      r = $urandom_range(0, 99);
      row.known = 1'b0;
      row.thr   = '0;
      row.knob  = KNOB_W'($urandom);
      if (r < 80) begin
         row.tgt  = (r < 10) ? 16'($urandom_range(1, 32767)) : 16'($urandom_range(1, 8000));
         row.meas = row.tgt + $signed(16'($urandom_range(0, 600))) - 16'sd300;
      end else if (r < 90) begin
         row.tgt  = SPEED_W'($urandom);
         row.meas = SPEED_W'($urandom);
      end else begin
         row.tgt  = -$signed(16'($urandom_range(0, 32767)));
         row.meas = SPEED_W'($urandom);
      end
      if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
      else clock_ms = clock_ms +
                      $urandom_range(0, 32'(2 * (interval < 200 ? interval : 200) + 2));
      row.now = clock_ms;
      return row;
   endfunction

   // rsp side back-pressure
   initial begin
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         rsp_ready <= 1'b1;
         repeat ($urandom_range(0, 8)) @(posedge clock);
         if (pick_gap() > 0) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end
      end
   end

   // result check and cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (throttle_queue.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_throttle, 0);
         end else if (rsp_throttle !== throttle_queue[0]) begin
            report_mismatch("throttle", rsp_throttle, throttle_queue[0]);
            void'(throttle_queue.pop_front());
         end else begin
            void'(throttle_queue.pop_front());
         end
      end
   end

   initial begin
      error_count = 0;
      quiet = 1'b0;
      clock_ms = 32'd1000;
      kp = PROP_GAIN_RST; kd = DERIV_GAIN_RST; ki = INTEG_GAIN_RST;
      lim_lo = $signed(OUT_MIN_RST); lim_hi = $signed(OUT_MAX_RST);
      interval = INTERVAL_RST;
      foreach (knob_ring_m[i]) knob_ring_m[i] = 0;
      ring_ptr = 0; ring_fill = 0; ring_sum = 0;
      integ_m = 0; last_err_m = 0; held_m = 0; last_ms_m = '0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_measured_speed <= '0;
      req_target_speed <= '0;
      req_knob_sample <= '0;
      req_now_ms <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) send_tick(dir_rows[i]);
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) set_phase(ph);
         quiet = (ph == 3);
         repeat (PHASE_ITEMS) send_tick(random_tick());
      end
      req_valid <= 1'b0;
      while (throttle_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
